// ===== rtl/csma_pkg.sv =====
// shared types and constants for the csma/ca backoff arbiter
// no dependencies; used by csma_ctrl, csma_dp and the top level
package csma_pkg;

   localparam int CW_W        = 8;
   localparam int RATE_W      = 16;
   localparam int OVH_W       = 12;
   localparam int PAY_W       = 12;
   localparam int DRAWS_W     = 64;
   localparam int STA_W       = 3;
   localparam int AIR_W       = 13;
   localparam int STAT_W      = 32;
   localparam int MAX_STA     = 8;
   localparam int STEPS       = 13;
   localparam int STEP_W      = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 192;

   localparam logic [PAY_W:0]      MAX_PAYLOAD_MOD = 13'd2347;
   localparam logic [CW_W-1:0]     CW_RESET        = 8'd31;
   localparam logic [RATE_W-1:0]   RATE_RESET      = 16'd500;
   localparam logic [OVH_W-1:0]    OVH_RESET       = 12'(20*8 + 14*8 + 14*8);

   localparam logic [CSR_ADDR_W-1:0] CSR_CW   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OVH  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } sts_type;

endpackage

// ===== rtl/csma_ctrl.sv =====
// sequencer for the csma/ca arbiter: load, divide steps, commit
// depends on csma_pkg
module csma_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               rsp_tready,
   input  csma_pkg::sts_type  sts,
   output csma_pkg::cmd_type  cmd
);

   csma_pkg::state_type             state_ff, state_in;
   logic [csma_pkg::STEP_W-1:0]     step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csma_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         csma_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = csma_pkg::ST_CALC;
            end
         end
         csma_pkg::ST_CALC: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == csma_pkg::STEP_W'(csma_pkg::STEPS - 1)) begin
               state_in = csma_pkg::ST_FINISH;
            end
         end
         csma_pkg::ST_FINISH: begin
            // wait for room in the result register
            if (!sts.out_full || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = csma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csma_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/csma_dp.sv =====
// datapath for the csma/ca arbiter: config, dividers, station state, stats
// depends on csma_pkg
module csma_dp #(
   parameter int STATIONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [csma_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [csma_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [csma_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [csma_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  csma_pkg::cmd_type                   cmd,
   output csma_pkg::sts_type                   sts
);

   localparam int AW = csma_pkg::AIR_W;
   localparam int RW = csma_pkg::RATE_W;
   localparam int CW = csma_pkg::CW_W;
   localparam int SW = csma_pkg::STAT_W;
   localparam int TW = csma_pkg::STA_W;

   logic [CW-1:0]                 cw_ff;
   logic [RW-1:0]                 rate_ff;
   logic [csma_pkg::OVH_W-1:0]    ovh_ff;

   logic [AW-1:0]                 total_ff;
   logic [AW-1:0]                 dq_ff, dq_in;
   logic [RW-1:0]                 dr_ff, dr_in;
   logic [AW-1:0]                 ld_ff [STATIONS];
   logic [CW-1:0]                 lr_ff [STATIONS];
   logic [AW-1:0]                 ld_in [STATIONS];
   logic [CW-1:0]                 lr_in [STATIONS];

   logic [CW-1:0]                 bo_ff [STATIONS];
   logic [CW-1:0]                 bo_in [STATIONS];
   logic [SW-1:0]                 pk_ff [STATIONS];
   logic [SW-1:0]                 pk_in [STATIONS];
   logic                          started_ff;
   logic                          busy_ff, busy_in;
   logic [TW-1:0]                 sender_ff, sender_in;
   logic [AW-1:0]                 ticks_ff, ticks_in;
   logic [SW-1:0]                 coll_tot_ff, coll_tot_in;
   logic [SW-1:0]                 bits_ff, bits_in;
   logic [SW-1:0]                 busy_tot_ff, busy_tot_in;
   logic [SW-1:0]                 pkts_ff, pkts_in;

   logic                          out_valid_ff, out_valid_in;
   logic [csma_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic [csma_pkg::PAY_W-1:0]    pay_raw;
   logic [AW-1:0]                 pay_mod;
   logic [RW-1:0]                 rate_eff;
   logic [RW:0]                   dtrial;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff   <= csma_pkg::CW_RESET;
         rate_ff <= csma_pkg::RATE_RESET;
         ovh_ff  <= csma_pkg::OVH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            csma_pkg::CSR_CW:   cw_ff   <= csr_wdata[CW-1:0];
            csma_pkg::CSR_RATE: rate_ff <= csr_wdata;
            csma_pkg::CSR_OVH:  ovh_ff  <= csr_wdata[csma_pkg::OVH_W-1:0];
            default: ;
         endcase
      end
   end

   // payload reduction and airtime divider, one quotient bit per step
   assign pay_raw  = req_tdata[csma_pkg::PAY_W-1:0];
   assign pay_mod  = ({1'b0, pay_raw} >= csma_pkg::MAX_PAYLOAD_MOD) ?
                     ({1'b0, pay_raw} - csma_pkg::MAX_PAYLOAD_MOD) : {1'b0, pay_raw};
   assign rate_eff = (rate_ff == '0) ? RW'(1) : rate_ff;
   assign dtrial   = {dr_ff, dq_ff[AW-1]};

   always_comb begin
      dq_in = dq_ff;
      dr_in = dr_ff;
      if (cmd.load) begin
         dq_in = pay_mod + AW'(ovh_ff);
         dr_in = '0;
      end else if (cmd.step) begin
         if (dtrial >= {1'b0, rate_eff}) begin
            dr_in = RW'(dtrial - {1'b0, rate_eff});
            dq_in = {dq_ff[AW-2:0], 1'b1};
         end else begin
            dr_in = dtrial[RW-1:0];
            dq_in = {dq_ff[AW-2:0], 1'b0};
         end
      end
   end

   // one remainder lane per station for the backoff redraw
   always_comb begin
      logic [CW:0] t;
      for (int i = 0; i < STATIONS; i++) begin
         t = '0;
         ld_in[i] = ld_ff[i];
         lr_in[i] = lr_ff[i];
         if (cmd.load) begin
            ld_in[i] = AW'(req_tdata[csma_pkg::PAY_W + 8*i +: 8]);
            lr_in[i] = '0;
         end else if (cmd.step) begin
            t        = {lr_ff[i], ld_ff[i][AW-1]};
            ld_in[i] = {ld_ff[i][AW-2:0], 1'b0};
            lr_in[i] = (t >= {1'b0, cw_ff}) ? CW'(t - {1'b0, cw_ff}) : t[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         total_ff <= pay_mod + AW'(ovh_ff);
      end
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      for (int i = 0; i < STATIONS; i++) begin
         ld_ff[i] <= ld_in[i];
         lr_ff[i] <= lr_in[i];
      end
   end

   // tick evaluation from the finished division results
   logic [CW-1:0]        redraw [STATIONS];
   logic [CW-1:0]        cur    [STATIONS];
   logic [CW-1:0]        dec    [STATIONS];
   logic [STATIONS-1:0]  req;
   logic [TW-1:0]        req_sta;
   logic [TW:0]          req_cnt;
   logic                 win, coll, defer, done;
   logic                 busy_a;
   logic [TW-1:0]        sender_a;
   logic [AW-1:0]        air, air_a, ticks_b;
   logic [SW:0]          bits_sum;
   logic [SW-1:0]        win_pkts;

   always_comb begin
      for (int i = 0; i < STATIONS; i++) begin
         redraw[i] = (cw_ff == '0) ? CW'(1) : lr_ff[i] + 1'b1;
         cur[i]    = started_ff ? bo_ff[i] : redraw[i];
         if (busy_ff && sender_ff == TW'(i)) begin
            dec[i] = cur[i];
            req[i] = 1'b0;
         end else begin
            dec[i] = (cur[i] != '0) ? cur[i] - 1'b1 : cur[i];
            req[i] = (dec[i] == '0);
         end
      end
      req_sta = '0;
      for (int i = 0; i < STATIONS; i++) begin
         if (req[i]) req_sta = TW'(i);
      end
      req_cnt = (TW+1)'($countones(req));
      win     = !busy_ff && req_cnt == (TW+1)'(1);
      coll    = !busy_ff && req_cnt > (TW+1)'(1);
      defer   = busy_ff && req_cnt != '0;

      air = dq_ff + AW'(dr_ff != '0);
      if (air == '0) air = AW'(1);

      busy_a   = busy_ff | win;
      sender_a = win ? req_sta : sender_ff;
      air_a    = win ? air : ticks_ff;

      for (int i = 0; i < STATIONS; i++) begin
         bo_in[i] = ((coll || defer) && req[i]) ? redraw[i] : dec[i];
         pk_in[i] = pk_ff[i];
      end

      bits_sum    = {1'b0, bits_ff} + (SW+1)'(total_ff);
      bits_in     = bits_ff;
      pkts_in     = pkts_ff;
      coll_tot_in = coll_tot_ff;
      busy_tot_in = busy_tot_ff;
      win_pkts    = '0;
      if (win) begin
         bits_in = bits_sum[SW] ? '1 : bits_sum[SW-1:0];
         pkts_in = (pkts_ff == '1) ? pkts_ff : pkts_ff + 1'b1;
         for (int i = 0; i < STATIONS; i++) begin
            if (req_sta == TW'(i)) begin
               pk_in[i] = (pk_ff[i] == '1) ? pk_ff[i] : pk_ff[i] + 1'b1;
               win_pkts = pk_in[i];
            end
         end
      end
      if (coll) begin
         coll_tot_in = (coll_tot_ff == '1) ? coll_tot_ff : coll_tot_ff + 1'b1;
      end

      busy_in   = busy_a;
      sender_in = sender_a;
      ticks_b   = air_a;
      done      = 1'b0;
      if (busy_a) begin
         busy_tot_in = (busy_tot_ff == '1) ? busy_tot_ff : busy_tot_ff + 1'b1;
         ticks_b     = (air_a != '0) ? air_a - 1'b1 : air_a;
         if (ticks_b == '0) begin
            busy_in = 1'b0;
            done    = 1'b1;
            for (int i = 0; i < STATIONS; i++) begin
               if (sender_a == TW'(i)) bo_in[i] = redraw[i];
            end
         end
      end
      ticks_in = ticks_b;

      out_data_in = {4'b0, win_pkts, pkts_in, busy_tot_in, bits_in, coll_tot_in,
                     done, ticks_in, busy_in,
                     8'(req & {STATIONS{defer}}),
                     coll, win ? req_sta : TW'(0), win};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         busy_ff     <= 1'b0;
         sender_ff   <= '0;
         ticks_ff    <= '0;
         coll_tot_ff <= '0;
         bits_ff     <= '0;
         busy_tot_ff <= '0;
         pkts_ff     <= '0;
         for (int i = 0; i < STATIONS; i++) begin
            bo_ff[i] <= '0;
            pk_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         started_ff  <= 1'b1;
         busy_ff     <= busy_in;
         sender_ff   <= sender_in;
         ticks_ff    <= ticks_in;
         coll_tot_ff <= coll_tot_in;
         bits_ff     <= bits_in;
         busy_tot_ff <= busy_tot_in;
         pkts_ff     <= pkts_in;
         for (int i = 0; i < STATIONS; i++) begin
            bo_ff[i] <= bo_in[i];
            pk_ff[i] <= pk_in[i];
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
      if (cmd.commit) out_data_ff <= out_data_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign sts.out_full = out_valid_ff;

   a_busy_has_airtime: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (ticks_ff != '0))
      else $error("busy flag and airtime disagree");

   a_win_xor_coll: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[4]))
      else $error("winner and collision in the same tick");

   a_defer_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && busy_ff |=> !out_data_ff[0] && !out_data_ff[4])
      else $error("contention resolved on a busy medium");

endmodule

// ===== rtl/csma_ca_backoff_arbiter.sv =====
// top level of the csma/ca random backoff arbiter
// depends on csma_pkg, csma_ctrl and csma_dp
// flow: accept, 13 divide steps, then commit into the registered result (rsp_tvalid)
// a new tick is accepted only once the previous one has committed, as the divide is shared
// a pending result in the output register does not stop the next divide
// reset: synchronous, active high; clears station state, stats and config to defaults
module csma_ca_backoff_arbiter #(
   parameter int STATIONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // config write port
   input  logic                                csr_we,
   input  logic [csma_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [csma_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // tick transaction in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // packet_draw[11:0], backoff_draws[75:12], zero pad[79:76]
   input  logic [csma_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result transaction out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // winner_valid[0], winner_station[3:1], collision[4], deferred_mask[12:5],
   // medium_busy[13], airtime_left[26:14], transmission_done[27],
   // collision_total[59:28], bits_total[91:60], busy_ticks_total[123:92],
   // packets_total[155:124], winner_packets[187:156], zero pad[191:188]
   output logic [csma_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   csma_pkg::cmd_type cmd;
   csma_pkg::sts_type sts;

   // sequencer
   csma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // dividers, per-station backoff and statistics
   csma_dp #(
      .STATIONS (STATIONS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
